FILE: hw/rtl/cic_pkg.sv
// Shared types, codes and constants for the coprocessor instruction cache.
// No dependencies; every other file but cic_ram imports this package.
package cic_pkg;

  // Cache geometry defaults
  localparam int CIC_CACHE_BYTES = 512;
  localparam int CIC_LINE_BYTES  = 16;
  localparam int CIC_LINE_COUNT  = 32;

  // Field widths
  localparam int ACTION_W    = 3;
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int BANK_W      = 8;
  localparam int KIND_W      = 2;
  localparam int SPACE_W     = 2;
  localparam int OFFSET_W    = 24;
  localparam int BUS_W       = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_FETCH      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RETURN     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH      = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_HOST_READ  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_HOST_WRITE = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_OPCODE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOST   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd3;

  // Request targets
  localparam logic [SPACE_W-1:0] SPACE_ROM  = 2'd0;
  localparam logic [SPACE_W-1:0] SPACE_RAM  = 2'd1;
  localparam logic [SPACE_W-1:0] SPACE_OPEN = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_BASE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROGRAM_BANK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROM_MASK     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RAM_MASK     = 2'd3;

  localparam logic [OFFSET_W-1:0] ROM_MASK_RESET = 24'h1fffff;
  localparam logic [OFFSET_W-1:0] RAM_MASK_RESET = 24'h01ffff;

  // Address map
  localparam logic [BUS_W-1:0] MAP_LOROM_SEL  = 24'hc00000;
  localparam logic [BUS_W-1:0] MAP_HIGH_SEL   = 24'he00000;
  localparam logic [BUS_W-1:0] MAP_LINEAR_ROM = 24'h400000;
  localparam logic [BUS_W-1:0] MAP_RAM        = 24'h600000;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FILL = 2'd1,
    MODE_PASS = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_HIT,
    OP_MISS,
    OP_OUTSIDE,
    OP_PASS_BYTE,
    OP_FILL_BYTE,
    OP_FILL_LAST,
    OP_FLUSH,
    OP_HOST_READ,
    OP_HOST_WRITE
  } op_t;

  typedef enum logic [2:0] {
    SEL_RAM_OPCODE,
    SEL_RAM_HOST,
    SEL_DATA,
    SEL_ACK,
    SEL_REQ
  } out_sel_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_PEND,
    ST_EMIT_OPCODE,
    ST_EMIT_HOST,
    ST_EMIT_DATA,
    ST_EMIT_ACK,
    ST_EMIT_REQ
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     clear_step;
    logic     read_pend;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic clear_last;
    logic out_free;
    logic req_last;
  } status_t;

  typedef struct packed {
    logic [SPACE_W-1:0]  space;
    logic [OFFSET_W-1:0] offset;
  } map_t;

  // Translate a 24-bit bus address into a target space and masked offset.
  function automatic map_t cic_map(input logic [BUS_W-1:0] bus,
                                   input logic [OFFSET_W-1:0] rom_mask,
                                   input logic [OFFSET_W-1:0] ram_mask);
    map_t m;
    m.space  = SPACE_OPEN;
    m.offset = '0;
    if ((bus & MAP_LOROM_SEL) == '0) begin
      m.space  = SPACE_ROM;
      m.offset = {3'b000, bus[21:16], bus[14:0]} & rom_mask;
    end else if ((bus & MAP_HIGH_SEL) == MAP_LINEAR_ROM) begin
      m.space  = SPACE_ROM;
      m.offset = bus & rom_mask;
    end else if ((bus & MAP_HIGH_SEL) == MAP_RAM) begin
      m.space  = SPACE_RAM;
      m.offset = bus & ram_mask;
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/cic_if.sv
// Channel interfaces of the instruction cache: item, result and config write.
// Depends on cic_pkg for field widths.
interface cic_item_if import cic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   data;

  modport source (output valid, output action, output address, output data, input ready);
  modport sink   (input valid, input action, input address, input data, output ready);
endinterface

interface cic_result_if import cic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SPACE_W-1:0]  space;
  logic [OFFSET_W-1:0] mem_offset;
  logic [DATA_W-1:0]   byte_out;
  logic                last;

  modport source (output valid, output kind, output space, output mem_offset,
                  output byte_out, output last, input ready);
  modport sink   (input valid, input kind, input space, input mem_offset,
                  input byte_out, input last, output ready);
endinterface

interface cic_cfg_if import cic_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/cic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/cic_ctrl.sv
// Sequencing state machine of the instruction cache.
// Depends on cic_pkg; drives cmd_t to the datapath and reads its status_t.
module cic_ctrl import cic_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) begin
          case (status.op)
            OP_HIT:                   state_next = ST_EMIT_OPCODE;
            OP_HOST_READ:             state_next = ST_EMIT_HOST;
            OP_MISS, OP_OUTSIDE:      state_next = ST_EMIT_REQ;
            OP_PASS_BYTE:             state_next = ST_EMIT_DATA;
            OP_FILL_LAST:             state_next = ST_READ_PEND;
            OP_FLUSH, OP_HOST_WRITE:  state_next = ST_EMIT_ACK;
            default:                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ_PEND: state_next = ST_EMIT_OPCODE;
      ST_EMIT_OPCODE, ST_EMIT_HOST, ST_EMIT_DATA, ST_EMIT_ACK: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_EMIT_REQ: begin
        if (status.out_free && status.req_last) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    item_ready     = (state == ST_IDLE);
    cmd            = '0;
    cmd.out_sel    = SEL_ACK;
    cmd.accept     = (state == ST_IDLE) && item_valid;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.read_pend  = (state == ST_READ_PEND);
    case (state)
      ST_EMIT_OPCODE: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = SEL_RAM_OPCODE;
      end
      ST_EMIT_HOST: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = SEL_RAM_HOST;
      end
      ST_EMIT_DATA: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = SEL_DATA;
      end
      ST_EMIT_ACK: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = SEL_ACK;
      end
      ST_EMIT_REQ: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = SEL_REQ;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/cic_datapath.sv
// Datapath of the instruction cache: config registers, valid bits, fill
// tracking, request generator, line store RAM and result register.
// Depends on cic_pkg and cic_ram.
module cic_datapath import cic_pkg::*; #(
  parameter int CACHE_BYTES = CIC_CACHE_BYTES,
  parameter int LINE_BYTES  = CIC_LINE_BYTES,
  parameter int LINE_COUNT  = CIC_LINE_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [ACTION_W-1:0]    item_action,
  input  logic [ADDR_W-1:0]      item_address,
  input  logic [DATA_W-1:0]      item_data,
  input  logic                   result_ready,
  output logic                   result_valid,
  output logic [KIND_W-1:0]      result_kind,
  output logic [SPACE_W-1:0]     result_space,
  output logic [OFFSET_W-1:0]    result_mem_offset,
  output logic [DATA_W-1:0]      result_byte_out,
  output logic                   result_last,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(CACHE_BYTES);
  localparam int LB_W  = $clog2(LINE_BYTES);
  localparam int LC_W  = $clog2(LINE_COUNT);
  localparam logic [ADDR_W-1:0] LINE_MASK = ADDR_W'(LINE_BYTES - 1);
  localparam logic [ADDR_W-1:0] WINDOW    = ADDR_W'(CACHE_BYTES);
  localparam logic [LB_W-1:0]   LINE_END  = LB_W'(LINE_BYTES - 1);

  // Configuration
  logic [ADDR_W-1:0]   code_base;
  logic [BANK_W-1:0]   program_bank;
  logic [OFFSET_W-1:0] rom_mask;
  logic [OFFSET_W-1:0] ram_mask;

  // Cache state
  logic [LINE_COUNT-1:0] line_valid;
  mode_t                 pending_mode;
  logic [LB_W-1:0]       fill_count;
  logic [IDX_W-1:0]      fill_index;
  logic [IDX_W-1:0]      pending_offset;
  logic [IDX_W-1:0]      clr_idx;

  // Request generator and held byte
  logic [BUS_W-1:0]  req_bus;
  logic [LB_W-1:0]   req_n;
  logic              req_single;
  logic [DATA_W-1:0] data_hold;

  // Decode
  op_t               op;
  logic [ADDR_W-1:0] fetch_off;
  logic              in_window;
  logic [LC_W-1:0]   fetch_line;
  logic [ADDR_W-1:0] bus_base;
  logic [IDX_W-1:0]  host_idx;
  logic [LC_W-1:0]   host_line;
  logic [IDX_W-1:0]  fill_idx;
  logic [LC_W-1:0]   pend_line;
  logic              req_last;
  map_t              req_map;

  // RAM
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Result load
  logic [KIND_W-1:0]   load_kind;
  logic [SPACE_W-1:0]  load_space;
  logic [OFFSET_W-1:0] load_offset;
  logic [DATA_W-1:0]   load_byte;
  logic                load_last;

  assign fetch_off  = item_address - code_base;
  assign in_window  = fetch_off < WINDOW;
  assign fetch_line = LC_W'(fetch_off >> LB_W);
  assign bus_base   = (code_base + (fetch_off & ~LINE_MASK)) & ~LINE_MASK;
  assign host_idx   = IDX_W'(item_address + code_base);
  assign host_line  = LC_W'(host_idx >> LB_W);
  assign fill_idx   = fill_index + IDX_W'(fill_count);
  assign pend_line  = LC_W'(pending_offset >> LB_W);
  assign req_last   = req_single || (req_n == LINE_END);
  assign req_map    = cic_map(req_bus | BUS_W'(req_n), rom_mask, ram_mask);

  always_comb begin
    op = OP_NONE;
    case (item_action)
      ACT_FETCH: begin
        if (!in_window)                  op = OP_OUTSIDE;
        else if (line_valid[fetch_line]) op = OP_HIT;
        else                             op = OP_MISS;
      end
      ACT_RETURN: begin
        case (pending_mode)
          MODE_PASS: op = OP_PASS_BYTE;
          MODE_FILL: op = (fill_count == LINE_END) ? OP_FILL_LAST : OP_FILL_BYTE;
          default:   op = OP_NONE;
        endcase
      end
      ACT_FLUSH:      op = OP_FLUSH;
      ACT_HOST_READ:  op = OP_HOST_READ;
      ACT_HOST_WRITE: op = OP_HOST_WRITE;
      default:        op = OP_NONE;
    endcase
  end

  always_comb begin
    status            = '0;
    status.op         = op;
    status.clear_last = &clr_idx;
    status.out_free   = !result_valid || result_ready;
    status.req_last   = req_last;
  end

  // RAM ports: the clearing sweep owns the write port until it finishes
  always_comb begin
    ram_we    = cmd.clear_step ||
                (cmd.accept && (op inside {OP_FILL_BYTE, OP_FILL_LAST, OP_HOST_WRITE}));
    ram_waddr = fill_idx;
    ram_wdata = item_data;
    if (cmd.clear_step) begin
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (op == OP_HOST_WRITE) begin
      ram_waddr = host_idx;
    end
    ram_re    = cmd.read_pend || (cmd.accept && (op inside {OP_HIT, OP_HOST_READ}));
    ram_raddr = host_idx;
    if (cmd.read_pend) begin
      ram_raddr = pending_offset;
    end else if (op == OP_HIT) begin
      ram_raddr = IDX_W'(fetch_off);
    end
  end

  cic_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CACHE_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      code_base    <= '0;
      program_bank <= '0;
      rom_mask     <= ROM_MASK_RESET;
      ram_mask     <= RAM_MASK_RESET;
      line_valid   <= '0;
      pending_mode <= MODE_IDLE;
      fill_count   <= '0;
      clr_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CODE_BASE:    code_base    <= ADDR_W'(cfg_data);
          REG_PROGRAM_BANK: program_bank <= BANK_W'(cfg_data);
          REG_ROM_MASK:     rom_mask     <= cfg_data;
          REG_RAM_MASK:     ram_mask     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.accept) begin
        case (op)
          OP_HIT:       pending_mode <= MODE_IDLE;
          OP_MISS: begin
            pending_mode <= MODE_FILL;
            fill_count   <= '0;
          end
          OP_OUTSIDE:   pending_mode <= MODE_PASS;
          OP_PASS_BYTE: pending_mode <= MODE_IDLE;
          OP_FILL_BYTE: fill_count   <= fill_count + 1'b1;
          OP_FILL_LAST: begin
            pending_mode          <= MODE_IDLE;
            fill_count            <= '0;
            line_valid[pend_line] <= 1'b1;
          end
          OP_FLUSH:     line_valid <= '0;
          OP_HOST_WRITE: begin
            if (&host_idx[LB_W-1:0]) line_valid[host_line] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_hold <= item_data;
      if (op == OP_MISS) begin
        fill_index     <= IDX_W'(fetch_off & ~LINE_MASK);
        pending_offset <= IDX_W'(fetch_off);
        req_bus        <= {program_bank, bus_base};
        req_n          <= '0;
        req_single     <= 1'b0;
      end else if (op == OP_OUTSIDE) begin
        req_bus    <= {program_bank, item_address};
        req_n      <= '0;
        req_single <= 1'b1;
      end
    end else if (cmd.out_load && cmd.out_sel == SEL_REQ) begin
      req_n <= req_n + 1'b1;
    end
  end

  always_comb begin
    load_kind   = KIND_ACK;
    load_space  = SPACE_ROM;
    load_offset = '0;
    load_byte   = '0;
    load_last   = 1'b1;
    case (cmd.out_sel)
      SEL_RAM_OPCODE: begin
        load_kind = KIND_OPCODE;
        load_byte = ram_rdata;
      end
      SEL_RAM_HOST: begin
        load_kind = KIND_HOST;
        load_byte = ram_rdata;
      end
      SEL_DATA: begin
        load_kind = KIND_OPCODE;
        load_byte = data_hold;
      end
      SEL_REQ: begin
        load_kind   = KIND_REQ;
        load_space  = req_map.space;
        load_offset = req_map.offset;
        load_last   = req_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_kind       <= load_kind;
      result_space      <= load_space;
      result_mem_offset <= load_offset;
      result_byte_out   <= load_byte;
      result_last       <= load_last;
    end
  end

endmodule

FILE: hw/rtl/coprocessor_instruction_cache.sv
// Coprocessor instruction cache: direct window of CACHE_BYTES bytes at code_base.
// Depends on cic_pkg, cic_if, cic_ctrl and cic_datapath.
//
// Channels: item (sink) carries action/address/data, result (source) carries
// kind/space/mem_offset/byte_out/last, cfg (sink) writes code_base,
// program_bank, rom_mask and ram_mask by index 0..3; cfg is always ready.
// Steps per item; the block takes one item at a time:
//   fetch hit, host read     line store read, then result register
//   fetch miss               LINE_BYTES requests, one per cycle unless stalled
//   fetch outside window     one read request
//   returned byte mid-fill   no result
//   returned byte, last      write, read back opcode, result
//   flush, host write        acknowledge
// Reset: all valid bits drop and the line store is swept to zero, one byte per
// cycle over every address; items wait during the sweep, config is taken.
// A stalled receiver holds the result register; the block then stays in its
// emit step and does not take the next item until the result transfers.
module coprocessor_instruction_cache import cic_pkg::*; #(
  parameter int CACHE_BYTES = CIC_CACHE_BYTES,
  parameter int LINE_BYTES  = CIC_LINE_BYTES,
  parameter int LINE_COUNT  = CIC_LINE_COUNT
) (
  input logic          clk,
  input logic          rst,
  cic_item_if.sink     item,
  cic_result_if.source result,
  cic_cfg_if.sink      cfg
);

  cmd_t    cmd;
  status_t status;

  // Cfg writes land at once, unchecked; issue them only while the block is quiet
  assign cfg.ready = 1'b1;

  cic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .item_ready(item.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cic_datapath #(
    .CACHE_BYTES(CACHE_BYTES),
    .LINE_BYTES (LINE_BYTES),
    .LINE_COUNT (LINE_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .item_action      (item.action),
    .item_address     (item.address),
    .item_data        (item.data),
    .result_ready     (result.ready),
    .result_valid     (result.valid),
    .result_kind      (result.kind),
    .result_space     (result.space),
    .result_mem_offset(result.mem_offset),
    .result_byte_out  (result.byte_out),
    .result_last      (result.last),
    .cfg_write        (cfg.valid && cfg.ready),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data)
  );

endmodule

FILE: hw/rtl/cic_checker.sv
// Port-level checks for the instruction cache, bound to the top level.
// Depends on cic_pkg and coprocessor_instruction_cache.
module cic_checker import cic_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic [ACTION_W-1:0] item_action,
  input logic                result_valid,
  input logic                result_ready,
  input logic [KIND_W-1:0]   result_kind,
  input logic [SPACE_W-1:0]  result_space,
  input logic [OFFSET_W-1:0] result_mem_offset,
  input logic [DATA_W-1:0]   result_byte_out,
  input logic                result_last
);

  // No result leaves right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_kind) &&
      $stable(result_space) && $stable(result_mem_offset) &&
      $stable(result_byte_out) && $stable(result_last))
    else $error("stalled result changed");

  // Every fetch causes a result, so the item side closes behind it
  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_action == ACT_FETCH |=> !item_ready)
    else $error("item taken right after a fetch");

  // Only requests carry a target and offset
  a_nonreq_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind != KIND_REQ |->
      result_space == SPACE_ROM && result_mem_offset == '0)
    else $error("non-request result carries a target");

  // Requests carry no byte, and open bus requests carry no offset
  a_req_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_REQ |-> result_byte_out == '0 &&
      (result_space != SPACE_OPEN || result_mem_offset == '0))
    else $error("request result malformed");

endmodule

bind coprocessor_instruction_cache cic_checker u_cic_checker (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item.valid),
  .item_ready       (item.ready),
  .item_action      (item.action),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_kind      (result.kind),
  .result_space     (result.space),
  .result_mem_offset(result.mem_offset),
  .result_byte_out  (result.byte_out),
  .result_last      (result.last)
);

FILE: test/tb_coprocessor_instruction_cache.sv
// Self-checking testbench for the coprocessor instruction cache: fetch hits,
// line fills, pass-through fetches, host access and flush, checked per result.
// Depends on cic_pkg, the channel interfaces in cic_if and the cache RTL.
module tb_coprocessor_instruction_cache import cic_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Run-length limits
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;  // long receiver hold-off under pressure
  localparam int DRAIN_CYCLES = 8;    // covers a no-result item still in flight
  localparam int PHASE_ITEMS  = 55;

  // One result as it leaves the block
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SPACE_W-1:0]  space;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   byte_val;
    logic                last;
  } cache_reply_t;

  logic clk = 1'b0;
  logic rst;

  cic_item_if   item_ch ();
  cic_result_if result_ch ();
  cic_cfg_if    cfg_ch ();

  coprocessor_instruction_cache i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the configuration registers
  logic [ADDR_W-1:0]   win_base      = '0;
  logic [BANK_W-1:0]   prog_bank     = '0;
  logic [OFFSET_W-1:0] rom_size_mask = ROM_MASK_RESET;
  logic [OFFSET_W-1:0] ram_size_mask = RAM_MASK_RESET;

  // Predictor copy of the cache state
  logic [DATA_W-1:0]         cache_copy [CIC_CACHE_BYTES];
  logic [CIC_LINE_COUNT-1:0] line_ok    = '0;
  mode_t                     cache_mode = MODE_IDLE;
  int                        fill_done  = 0;
  int                        fill_start = 0;
  int                        fetch_offset = 0;

  cache_reply_t awaited_results [$];

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  steady_flow = 1'b0;   // no idling on either side when set
  bit  hold_results = 1'b0;  // ask the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic expect_reply(input logic [KIND_W-1:0] kind, input logic [SPACE_W-1:0] space,
                              input logic [OFFSET_W-1:0] offset,
                              input logic [DATA_W-1:0] byte_val, input logic last);
    cache_reply_t r;
    r.kind     = kind;
    r.space    = space;
    r.offset   = offset;
    r.byte_val = byte_val;
    r.last     = last;
    awaited_results.push_back(r);
  endtask

  // Decode a 24-bit bus address: LoROM below bank 40, linear ROM in 40-5f,
  // RAM in 60-7f, open bus above.
  task automatic bus_target(input logic [BUS_W-1:0] bus, output logic [SPACE_W-1:0] space,
                            output logic [OFFSET_W-1:0] offset);
    if (bus[23:22] == 2'b00) begin
      space  = SPACE_ROM;
      offset = (((bus & 24'h3f0000) >> 1) | (bus & 24'h007fff)) & rom_size_mask;
    end else if (bus[23:21] == 3'b010) begin
      space  = SPACE_ROM;
      offset = bus & rom_size_mask;
    end else if (bus[23:21] == 3'b011) begin
      space  = SPACE_RAM;
      offset = bus & ram_size_mask;
    end else begin
      space  = SPACE_OPEN;
      offset = '0;
    end
  endtask

  // Advance the predicted cache by one accepted item and queue its results.
  task automatic apply_cache_action(input logic [ACTION_W-1:0] act,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [DATA_W-1:0] dat);
    logic [ADDR_W-1:0]   win_off;
    logic [ADDR_W-1:0]   line_base;
    logic [ADDR_W-1:0]   host_sum;
    logic [SPACE_W-1:0]  sp;
    logic [OFFSET_W-1:0] off;
    int                  slot;
    case (act)
      ACT_FETCH: begin
        win_off    = addr - win_base;
        cache_mode = MODE_IDLE;  // any pending request is abandoned
        if (win_off < CIC_CACHE_BYTES) begin
          if (line_ok[(win_off / CIC_LINE_BYTES) % CIC_LINE_COUNT]) begin
            expect_reply(KIND_OPCODE, '0, '0, cache_copy[win_off], 1'b1);
          end else begin
            // Miss: request the whole line, aligned on the bus
            line_base = win_base + (win_off - win_off % CIC_LINE_BYTES);
            line_base = line_base - line_base % CIC_LINE_BYTES;
            for (int n = 0; n < CIC_LINE_BYTES; n++) begin
              bus_target({prog_bank, line_base} + BUS_W'(n), sp, off);
              expect_reply(KIND_REQ, sp, off, '0, n == CIC_LINE_BYTES - 1);
            end
            cache_mode   = MODE_FILL;
            fill_done    = 0;
            fill_start   = win_off - win_off % CIC_LINE_BYTES;
            fetch_offset = win_off;
          end
        end else begin
          bus_target({prog_bank, addr}, sp, off);
          expect_reply(KIND_REQ, sp, off, '0, 1'b1);
          cache_mode = MODE_PASS;
        end
      end
      ACT_RETURN: begin
        if (cache_mode == MODE_PASS) begin
          cache_mode = MODE_IDLE;
          expect_reply(KIND_OPCODE, '0, '0, dat, 1'b1);
        end else if (cache_mode == MODE_FILL) begin
          cache_copy[(fill_start + fill_done) % CIC_CACHE_BYTES] = dat;
          fill_done++;
          if (fill_done >= CIC_LINE_BYTES) begin
            line_ok[(fetch_offset / CIC_LINE_BYTES) % CIC_LINE_COUNT] = 1'b1;
            cache_mode = MODE_IDLE;
            fill_done  = 0;
            expect_reply(KIND_OPCODE, '0, '0, cache_copy[fetch_offset % CIC_CACHE_BYTES], 1'b1);
          end
        end
        // a byte returned while idle is dropped
      end
      ACT_FLUSH: begin
        line_ok = '0;
        expect_reply(KIND_ACK, '0, '0, '0, 1'b1);
      end
      ACT_HOST_READ, ACT_HOST_WRITE: begin
        host_sum = addr + win_base;
        slot     = host_sum % CIC_CACHE_BYTES;
        if (act == ACT_HOST_READ) begin
          expect_reply(KIND_HOST, '0, '0, cache_copy[slot], 1'b1);
        end else begin
          cache_copy[slot] = dat;
          // writing the last byte of a line validates that line
          if (slot % CIC_LINE_BYTES == CIC_LINE_BYTES - 1)
            line_ok[(slot / CIC_LINE_BYTES) % CIC_LINE_COUNT] = 1'b1;
          expect_reply(KIND_ACK, '0, '0, '0, 1'b1);
        end
      end
      default: ;  // unknown actions are ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one item from the falling edge, with an optional idle burst first,
  // and update the predictor at the edge where it transfers.
  task automatic send_action(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] dat);
    int gap;
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 4) == 0) begin
      item_ch.valid = 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   = 1'b1;
    item_ch.action  = act;
    item_ch.address = addr;
    item_ch.data    = dat;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    apply_cache_action(act, addr, dat);
    items_sent++;
  endtask

  // Drop the item valid and hold until every queued result has transferred.
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; only called while the cache is drained.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CODE_BASE:    win_base      = value[ADDR_W-1:0];
      REG_PROGRAM_BANK: prog_bank     = value[BANK_W-1:0];
      REG_ROM_MASK:     rom_size_mask = value;
      REG_RAM_MASK:     ram_size_mask = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Zero, the field maximum, or a random value that may carry bits above the field.
  function automatic logic [CFG_DATA_W-1:0] extreme_or_random(input logic [CFG_DATA_W-1:0] top);
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return '0;
    if (pick == 1) return top;
    return CFG_DATA_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus building blocks
  // ---------------------------------------------------------------------------

  // Fetch, then answer it the way the memory side would: a full line of bytes
  // after a miss, one byte after a pass-through. Now and then cut a fill short
  // or slip a host access in while the request is pending.
  task automatic fetch_sequence();
    logic [ADDR_W-1:0] addr;
    int                pick;
    int                n_bytes;
    pick = $urandom_range(0, 9);
    if (pick < 5)      addr = win_base + ADDR_W'($urandom_range(0, 63));
    else if (pick < 7) addr = win_base + ADDR_W'($urandom_range(0, CIC_CACHE_BYTES - 1));
    else               addr = ADDR_W'($urandom);
    send_action(ACT_FETCH, addr, DATA_W'($urandom));
    if (cache_mode == MODE_FILL) begin
      n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CIC_LINE_BYTES - 1)
                                            : CIC_LINE_BYTES;
      for (int k = 0; k < n_bytes; k++) begin
        if ($urandom_range(0, 11) == 0)
          send_action(ACT_HOST_READ, ADDR_W'($urandom), DATA_W'($urandom));
        send_action(ACT_RETURN, ADDR_W'($urandom), DATA_W'($urandom));
      end
    end else if (cache_mode == MODE_PASS) begin
      if ($urandom_range(0, 5) == 0)
        send_action(ACT_HOST_WRITE, ADDR_W'($urandom), DATA_W'($urandom));
      send_action(ACT_RETURN, ADDR_W'($urandom), DATA_W'($urandom));
    end
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 58)
      fetch_sequence();
    else if (pick < 72)
      send_action(ACT_HOST_WRITE, ADDR_W'($urandom), DATA_W'($urandom));
    else if (pick < 82)
      send_action(ACT_HOST_READ, ADDR_W'($urandom), DATA_W'($urandom));
    else if (pick < 85)
      send_action(ACT_FLUSH, ADDR_W'($urandom), DATA_W'($urandom));
    else if (pick < 95)
      send_action(ACT_RETURN, ADDR_W'($urandom), DATA_W'($urandom));  // stray byte
    else
      send_action(ACT_HOST_WRITE + ACTION_W'($urandom_range(1, 3)),
                  ADDR_W'($urandom), DATA_W'($urandom));              // unknown action
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The sweep after reset must leave every byte at zero; read both ends.
  task automatic test_reset_contents();
    send_action(ACT_HOST_READ, 16'h0000, 8'h00);
    send_action(ACT_HOST_READ, 16'hffff, 8'hff);
  endtask

  // Validate a line through a host write to its last byte, hit it, then flush.
  task automatic test_host_access();
    send_action(ACT_HOST_WRITE, 16'h000f, 8'hff);
    send_action(ACT_FETCH, 16'h000f, 8'h00);
    send_action(ACT_FLUSH, 16'h0000, 8'h00);
  endtask

  // Miss, fill the line with a host read in the middle, then hit the new line.
  task automatic test_line_fill();
    send_action(ACT_FETCH, 16'h0010, 8'h00);
    for (int k = 0; k < CIC_LINE_BYTES; k++) begin
      if (k == 5) send_action(ACT_HOST_READ, 16'h0013, 8'h00);
      send_action(ACT_RETURN, 16'h0000, (k % 2 == 0) ? 8'h00 : 8'hff);
    end
    send_action(ACT_FETCH, 16'h001e, 8'h00);
  endtask

  // Pass-through fetch, stray byte while idle, unknown action, abandoned fill.
  task automatic test_outside_window();
    send_action(ACT_FETCH, 16'hffff, 8'h00);
    send_action(ACT_RETURN, 16'hffff, 8'ha5);
    send_action(ACT_RETURN, 16'h0000, 8'h3c);
    send_action(ACT_HOST_WRITE + ACTION_W'(3), 16'h0000, 8'hff);
    send_action(ACT_FETCH, 16'h0100, 8'h00);
    send_action(ACT_RETURN, 16'h0000, 8'h11);
    send_action(ACT_RETURN, 16'h0000, 8'h22);
    send_action(ACT_FETCH, 16'h8000, 8'h00);  // drops the partial fill
    send_action(ACT_RETURN, 16'h0000, 8'h5a);
  endtask

  // One pass-through fetch in each region of the address map.
  task automatic test_address_map();
    logic [BANK_W-1:0] banks [4];
    banks = '{8'h3f, 8'h5f, 8'h7f, 8'hff};
    wait_drained();
    write_register(REG_CODE_BASE, 24'h00ffff);
    write_register(REG_ROM_MASK, 24'hffffff);
    write_register(REG_RAM_MASK, 24'hffffff);
    foreach (banks[b]) begin
      wait_drained();
      write_register(REG_PROGRAM_BANK, {16'h0000, banks[b]});
      send_action(ACT_FETCH, 16'h7fff, 8'h00);
      send_action(ACT_RETURN, 16'h0000, 8'hc3);
    end
  endtask

  // New register settings, then mostly well-formed fetch traffic.
  task automatic test_random_traffic(input int n_items);
    int target;
    wait_drained();
    write_register(REG_CODE_BASE, extreme_or_random(24'h00ffff));
    write_register(REG_PROGRAM_BANK, extreme_or_random(24'h0000ff));
    write_register(REG_ROM_MASK, extreme_or_random(24'hffffff));
    write_register(REG_RAM_MASK, extreme_or_random(24'hffffff));
    target = items_sent + n_items;
    while (items_sent < target) random_step();
  endtask

  // Hold the receiver off while items keep coming, so the block backs up and
  // stalls its input; then pause the sender until everything has drained.
  task automatic test_result_backpressure();
    int target;
    wait_drained();
    hold_results = 1'b1;
    target = items_sent + 24;
    while (items_sent < target) random_step();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each transfer with the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cache_reply_t got;
    cache_reply_t want;
    if (result_ch.valid && result_ch.ready) begin
      got.kind     = result_ch.kind;
      got.space    = result_ch.space;
      got.offset   = result_ch.mem_offset;
      got.byte_val = result_ch.byte_out;
      got.last     = result_ch.last;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind=%0d space=%0d offset=%h byte=%h last=%0d",
                   $realtime, got.kind, got.space, got.offset, got.byte_val, got.last);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result differs: expected kind=%0d space=%0d offset=%h byte=%h ",
                     $realtime, want.kind, want.space, want.offset, want.byte_val,
                     "last=%0d, got kind=%0d space=%0d offset=%h byte=%h last=%0d",
                     want.last, got.kind, got.space, got.offset, got.byte_val, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
        result_ch.ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      result_ch.ready = 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.action  = ACT_FETCH;
    item_ch.address = '0;
    item_ch.data    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_CODE_BASE;
    cfg_ch.data     = '0;
    foreach (cache_copy[i]) cache_copy[i] = '0;

    // Synchronous reset; the block then sweeps its line store before taking items
    rst = 1'b1;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_reset_contents();
    test_host_access();
    test_line_fill();
    test_outside_window();
    test_address_map();
    for (int p = 0; p < 4; p++) test_random_traffic(PHASE_ITEMS);
    test_result_backpressure();

    // Final stretch runs back to back with no idling on either side
    steady_flow = 1'b1;
    test_random_traffic(PHASE_ITEMS);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
